@@ rtl/arp_pkg.sv @@
// Shared types, constants and helpers for the note arpeggiator.
// Used by arp_lane, arp_step and note_arpeggiator; depends on nothing.
package arp_pkg;

    localparam int MAX_NOTES   = 8;
    localparam int NOTE_FIELDS = 8;
    localparam int LANES       = (MAX_NOTES < NOTE_FIELDS) ? MAX_NOTES : NOTE_FIELDS;
    localparam int IDX_W       = $clog2(MAX_NOTES);
    localparam int CNT_W       = $clog2(LANES + 1);
    localparam int SIDX_W      = IDX_W + 2;

    localparam int NOTE_W      = 7;
    localparam int CNT_IN_W    = 4;
    localparam int PER_W       = 16;
    localparam int MODE_W      = 4;
    localparam int PAT_W       = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int S_FIELD_W   = CNT_IN_W + NOTE_FIELDS * NOTE_W + 1;
    localparam int S_DATA_W    = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W    = 8;
    localparam int VGATE_BIT   = CNT_IN_W + NOTE_FIELDS * NOTE_W;

    localparam logic [CFG_ADDR_W-1:0] REG_ARP_MODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_PERIOD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FAST_PERIOD = 2'd2;

    localparam logic [MODE_W-1:0] MODE_OFF  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_MAX  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_FAST = 4'd5;
    localparam logic [MODE_W-1:0] FAST_OFS  = 4'd4;

    localparam logic [PAT_W-1:0] PAT_OFF    = 3'd0;
    localparam logic [PAT_W-1:0] PAT_UP     = 3'd1;
    localparam logic [PAT_W-1:0] PAT_DOWN   = 3'd2;
    localparam logic [PAT_W-1:0] PAT_UPDOWN = 3'd3;
    localparam logic [PAT_W-1:0] PAT_PLAYED = 3'd4;

    localparam logic [PER_W-1:0]  SLOW_RESET = 16'd9600;
    localparam logic [PER_W-1:0]  FAST_RESET = 16'd4800;
    localparam logic [NOTE_W-1:0] NOTE_RESET = 7'd60;

    typedef logic [NOTE_W-1:0] t_note;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic sort_en;
        logic descend;
    } t_sort;

    typedef struct packed {
        logic                  vgate;
        t_cnt                  count;
        t_note [LANES-1:0]     notes;
        t_idx  [LANES-1:0]     ranks;
    } t_tick;

    function automatic logic [PAT_W-1:0] pattern_of(input logic [MODE_W-1:0] mode);
        logic [MODE_W-1:0] p;
        p = (mode >= MODE_FAST) ? (mode - FAST_OFS) : mode;
        return p[PAT_W-1:0];
    endfunction

endpackage

@@ rtl/arp_lane.sv @@
// One sort lane: finds the position of its own note within the held list.
// Depends on arp_pkg.
module arp_lane (
    input  arp_pkg::t_note [arp_pkg::LANES-1:0] i_notes,
    input  arp_pkg::t_cnt                       i_count,
    input  arp_pkg::t_idx                       i_lane,
    input  arp_pkg::t_sort                      i_sort,
    output arp_pkg::t_idx                       o_rank
);

    arp_pkg::t_cnt w_acc;

    always_comb begin
        logic ahead;
        logic ni_eq;
        w_acc = '0;
        for (int j = 0; j < arp_pkg::LANES; j++) begin
            ni_eq = (i_notes[j] == i_notes[i_lane]);
            ahead = i_sort.descend ? (i_notes[j] > i_notes[i_lane])
                                   : (i_notes[j] < i_notes[i_lane]);
            if (ni_eq && (arp_pkg::IDX_W'(j) < i_lane)) begin
                ahead = 1'b1;
            end
            if ((arp_pkg::CNT_W'(j) < i_count) && (arp_pkg::IDX_W'(j) != i_lane) && ahead) begin
                w_acc = w_acc + 1'b1;
            end
        end
    end

    assign o_rank = i_sort.sort_en ? arp_pkg::IDX_W'(w_acc) : i_lane;

endmodule

@@ rtl/arp_step.sv @@
// Step sequencer: config registers, timer, index state, lane merge and result register.
// Depends on arp_pkg.
module arp_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [arp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [arp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_fire,
    input  arp_pkg::t_tick                     i_tick,
    output arp_pkg::t_sort                     o_sort,
    output arp_pkg::t_note                     o_note,
    output logic                               o_gate
);

    logic [arp_pkg::MODE_W-1:0] r_mode;
    logic [arp_pkg::PER_W-1:0]  r_slow;
    logic [arp_pkg::PER_W-1:0]  r_fast;
    arp_pkg::t_cnt              r_count;
    arp_pkg::t_idx              r_idx;
    logic                       r_down;
    logic [arp_pkg::PER_W-1:0]  r_timer;
    arp_pkg::t_note             r_held;
    logic                       r_gate;
    arp_pkg::t_note             r_onote;
    logic                       r_ogate;

    logic [arp_pkg::PAT_W-1:0]  w_pat;
    logic [arp_pkg::PER_W-1:0]  w_period;
    logic [arp_pkg::MODE_W-1:0] w_new_mode;
    logic                       w_first;
    logic                       w_hit;
    logic                       w_step;
    arp_pkg::t_idx              w_idx1;
    arp_pkg::t_idx              w_idx2;
    arp_pkg::t_idx              n_idx;
    logic                       n_down;
    logic [arp_pkg::PER_W:0]    w_t1;
    logic [arp_pkg::PER_W-1:0]  n_timer;
    arp_pkg::t_note             w_sel;
    arp_pkg::t_note             n_held;
    logic                       n_gate;
    logic signed [arp_pkg::SIDX_W-1:0] w_sidx;
    logic signed [arp_pkg::SIDX_W-1:0] w_slast;

    assign w_pat    = arp_pkg::pattern_of(r_mode);
    assign w_period = (r_mode >= arp_pkg::MODE_FAST) ? r_fast : r_slow;
    assign o_sort.sort_en = (w_pat == arp_pkg::PAT_UP) || (w_pat == arp_pkg::PAT_DOWN)
                         || (w_pat == arp_pkg::PAT_UPDOWN);
    assign o_sort.descend = (w_pat == arp_pkg::PAT_DOWN);
    assign w_new_mode = (i_cfg_data[arp_pkg::MODE_W-1:0] > arp_pkg::MODE_MAX)
                      ? arp_pkg::MODE_OFF : i_cfg_data[arp_pkg::MODE_W-1:0];

    always_comb begin
        w_first = (r_count == '0) && (i_tick.count != '0);
        if (i_tick.count == '0) begin
            w_idx1 = r_idx;
        end else if (w_first || (int'(r_idx) >= int'(i_tick.count))) begin
            w_idx1 = '0;
        end else begin
            w_idx1 = r_idx;
        end

        w_t1   = {1'b0, (w_first ? '0 : r_timer)} + 1'b1;
        w_hit  = (w_t1 >= {1'b0, w_period});
        w_step = w_hit && (i_tick.count != '0);
        n_timer = w_hit ? '0 : w_t1[arp_pkg::PER_W-1:0];

        // up-down bounce, signed so a step below zero is caught
        w_slast = $signed(arp_pkg::SIDX_W'(i_tick.count)) - arp_pkg::SIDX_W'(1);
        w_sidx  = $signed(arp_pkg::SIDX_W'(w_idx1)) + arp_pkg::SIDX_W'(r_down ? -1 : 1);
        n_down  = r_down;
        if (w_pat == arp_pkg::PAT_UPDOWN) begin
            if (w_sidx >= w_slast) begin
                w_idx2 = arp_pkg::IDX_W'(w_slast);
                n_down = w_step ? 1'b1 : r_down;
            end else if (w_sidx <= 0) begin
                w_idx2 = '0;
                n_down = w_step ? 1'b0 : r_down;
            end else begin
                w_idx2 = arp_pkg::IDX_W'(w_sidx);
            end
        end else begin
            w_idx2 = (int'(w_idx1) + 1 == int'(i_tick.count)) ? '0 : w_idx1 + 1'b1;
        end
        n_idx = w_step ? w_idx2 : w_idx1;

        // merge: pick the lane that landed at the step position
        w_sel = r_held;
        for (int i = 0; i < arp_pkg::LANES; i++) begin
            if ((arp_pkg::CNT_W'(i) < i_tick.count) && (i_tick.ranks[i] == n_idx)) begin
                w_sel = i_tick.notes[i];
            end
        end
        n_held = (w_first || w_step) ? w_sel : r_held;

        if (i_tick.count == '0) begin
            n_gate = 1'b0;
        end else begin
            n_gate = w_first ? 1'b1 : r_gate;
        end
        if (w_step) begin
            n_gate = 1'b1;
        end
        if (n_timer > (w_period >> 1)) begin
            n_gate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= arp_pkg::MODE_OFF;
            r_slow  <= arp_pkg::SLOW_RESET;
            r_fast  <= arp_pkg::FAST_RESET;
            r_count <= '0;
            r_idx   <= '0;
            r_down  <= 1'b0;
            r_timer <= '0;
            r_held  <= arp_pkg::NOTE_RESET;
            r_gate  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                arp_pkg::REG_ARP_MODE: begin
                    if (w_new_mode != r_mode) begin
                        r_mode  <= w_new_mode;
                        r_timer <= '0;
                        r_idx   <= '0;
                        r_down  <= 1'b0;
                        r_count <= '0;
                        r_gate  <= 1'b0;
                    end
                end
                arp_pkg::REG_SLOW_PERIOD: r_slow <= i_cfg_data;
                arp_pkg::REG_FAST_PERIOD: r_fast <= i_cfg_data;
                default: ;
            endcase
        end else if (i_fire) begin
            if (i_tick.vgate) begin
                r_count <= i_tick.count;
                r_idx   <= n_idx;
                r_down  <= n_down;
                r_timer <= n_timer;
                r_held  <= n_held;
                r_gate  <= n_gate;
            end else begin
                r_count <= '0;
                r_gate  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_onote <= i_tick.vgate ? n_held : r_held;
            r_ogate <= i_tick.vgate ? n_gate : 1'b0;
        end
    end

    assign o_note = r_onote;
    assign o_gate = r_ogate;

endmodule

@@ rtl/note_arpeggiator.sv @@
// Top level of the note arpeggiator: stream ports, sort lanes, stage register, step unit.
// Depends on arp_pkg, arp_lane and arp_step.
//
// One tick is taken per clock cycle unless the result stream holds it back; the result
// passes from the sort lanes into the stage register, then from the step unit into the
// result register. Each held note has its own lane that ranks it against the others
// combinationally; the step unit then picks the lane at the step position and updates
// the timer, index and gate, one tick per cycle when not stalled. No clearing pass follows
// reset. Configuration writes are taken every cycle and belong only to idle periods.
module note_arpeggiator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // held_count[3:0], note_0..note_7 7 bits each, voice_gate[60], zero fill
    input  logic [arp_pkg::S_DATA_W-1:0]      i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // out_note[6:0], out_gate[7]
    output logic [arp_pkg::M_DATA_W-1:0]      o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [arp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [arp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    arp_pkg::t_note [arp_pkg::LANES-1:0] w_notes;
    arp_pkg::t_idx  [arp_pkg::LANES-1:0] w_ranks;
    logic [arp_pkg::CNT_IN_W-1:0]        w_cnt_in;
    arp_pkg::t_cnt                       w_count;
    arp_pkg::t_sort                      w_sort;
    arp_pkg::t_tick                      r_s1;
    logic                                r_s1_valid;
    logic                                r_m_valid;
    logic                                w_fire2;
    logic                                w_take;
    arp_pkg::t_note                      w_onote;
    logic                                w_ogate;

    assign w_cnt_in = i_s_tdata[arp_pkg::CNT_IN_W-1:0];
    assign w_count  = (int'(w_cnt_in) > arp_pkg::LANES) ? arp_pkg::CNT_W'(arp_pkg::LANES)
                                                        : arp_pkg::CNT_W'(w_cnt_in);

    for (genvar g = 0; g < arp_pkg::LANES; g++) begin : g_lane
        assign w_notes[g] = i_s_tdata[arp_pkg::CNT_IN_W + g*arp_pkg::NOTE_W +: arp_pkg::NOTE_W];
        arp_lane u_lane (
            .i_notes (w_notes),
            .i_count (w_count),
            .i_lane  (arp_pkg::IDX_W'(g)),
            .i_sort  (w_sort),
            .o_rank  (w_ranks[g])
        );
    end

    assign w_fire2    = r_s1_valid && (!r_m_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_fire2;
    assign w_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_fire2) begin
                r_s1_valid <= 1'b0;
            end
            if (w_fire2) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1.vgate <= i_s_tdata[arp_pkg::VGATE_BIT];
            r_s1.count <= w_count;
            r_s1.notes <= w_notes;
            r_s1.ranks <= w_ranks;
        end
    end

    arp_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire2),
        .i_tick     (r_s1),
        .o_sort     (w_sort),
        .o_note     (w_onote),
        .o_gate     (w_ogate)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {w_ogate, w_onote};

    a_gate_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire2 && !r_s1.vgate) |=> (o_m_tdata[arp_pkg::NOTE_W] == 1'b0))
        else $error("gate high after a tick with the voice gate low");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_fire2) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stage register lost or changed a waiting tick");

    for (genvar r = 0; r < arp_pkg::LANES; r++) begin : g_chk
        logic [arp_pkg::LANES-1:0] w_hit;
        for (genvar i = 0; i < arp_pkg::LANES; i++) begin : g_hit
            assign w_hit[i] = (arp_pkg::CNT_W'(i) < r_s1.count)
                           && (r_s1.ranks[i] == arp_pkg::IDX_W'(r));
        end
        a_rank_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_s1_valid |-> $onehot0(w_hit))
            else $error("two lanes claim the same list position");
    end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for note_arpeggiator: tick stream in, note/gate stream out.
// Predicts each result from its own copy of the arpeggiator state; depends on arp_pkg.
module testbench;

    typedef struct packed {
        logic                                                gate;
        logic [arp_pkg::NOTE_FIELDS-1:0][arp_pkg::NOTE_W-1:0] notes;
        logic [arp_pkg::CNT_IN_W-1:0]                        count;
    } t_held_tick;

    typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_style;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [arp_pkg::S_DATA_W-1:0]    i_s_tdata = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [arp_pkg::M_DATA_W-1:0]    o_m_tdata;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [arp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [arp_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    note_arpeggiator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // arpeggiator state as predicted
    logic [arp_pkg::MODE_W-1:0]  mode_reg;
    int                          slow_ticks;
    int                          fast_ticks;
    logic [arp_pkg::NOTE_W-1:0]  voiced_notes [arp_pkg::MAX_NOTES];
    int                          voiced_count;
    int                          step_pos;
    bit                          step_down;
    int                          tick_timer;
    logic [arp_pkg::NOTE_W-1:0]  sounding_note;
    bit                          sounding_gate;

    t_held_tick                    tick_queue [$];
    logic [arp_pkg::M_DATA_W-1:0]  expected_results [$];
    int                 ticks_queued = 0;
    int                 ticks_accepted = 0;
    int                 errors = 0;
    bit                 tick_taken = 1'b0;
    bit                 cfg_taken = 1'b0;

    int                 gap_left = 0;
    int                 burst_left = 0;
    t_rx_style          rx_style = RX_STREAM;
    int                 rx_left = 0;

    task automatic reset_arpeggiator();
        mode_reg      = arp_pkg::MODE_OFF;
        slow_ticks    = int'(arp_pkg::SLOW_RESET);
        fast_ticks    = int'(arp_pkg::FAST_RESET);
        voiced_count  = 0;
        step_pos      = 0;
        step_down     = 1'b0;
        tick_timer    = 0;
        sounding_note = arp_pkg::NOTE_RESET;
        sounding_gate = 1'b0;
    endtask

    task automatic apply_register(input logic [arp_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [arp_pkg::CFG_DATA_W-1:0] value);
        logic [arp_pkg::MODE_W-1:0] m;
        if (addr == arp_pkg::REG_ARP_MODE) begin
            m = value[arp_pkg::MODE_W-1:0];
            if (m > arp_pkg::MODE_MAX)
                m = arp_pkg::MODE_OFF;
            if (m != mode_reg) begin
                tick_timer    = 0;
                step_pos      = 0;
                step_down     = 1'b0;
                voiced_count  = 0;
                sounding_gate = 1'b0;
                mode_reg      = m;
            end
        end else if (addr == arp_pkg::REG_SLOW_PERIOD) begin
            slow_ticks = int'(value);
        end else if (addr == arp_pkg::REG_FAST_PERIOD) begin
            fast_ticks = int'(value);
        end
    endtask

    task automatic arpeggiate(input t_held_tick t,
                              output logic [arp_pkg::M_DATA_W-1:0] result);
        int n, prev, per, i, j;
        logic [arp_pkg::MODE_W-1:0] pat;
        logic [arp_pkg::NOTE_W-1:0] tmp;
        bit swap;
        if (!t.gate) begin
            voiced_count  = 0;
            sounding_gate = 1'b0;
            result = {1'b0, sounding_note};
            return;
        end
        pat  = (mode_reg >= arp_pkg::MODE_FAST) ? mode_reg - arp_pkg::FAST_OFS : mode_reg;
        prev = voiced_count;
        n    = (int'(t.count) > arp_pkg::LANES) ? arp_pkg::LANES : int'(t.count);
        for (i = 0; i < n; i++)
            voiced_notes[i] = t.notes[i];
        voiced_count = n;
        if (n == 0) begin
            sounding_gate = 1'b0;
        end else begin
            if (pat == arp_pkg::PAT_UP || pat == arp_pkg::PAT_DOWN
                || pat == arp_pkg::PAT_UPDOWN) begin
                for (i = 0; i < n - 1; i++)
                    for (j = i + 1; j < n; j++) begin
                        swap = (pat == arp_pkg::PAT_DOWN)
                             ? (voiced_notes[j] > voiced_notes[i])
                             : (voiced_notes[j] < voiced_notes[i]);
                        if (swap) begin
                            tmp             = voiced_notes[i];
                            voiced_notes[i] = voiced_notes[j];
                            voiced_notes[j] = tmp;
                        end
                    end
            end
            if (step_pos >= n)
                step_pos = 0;
            if (prev == 0) begin
                step_pos      = 0;
                sounding_note = voiced_notes[0];
                sounding_gate = 1'b1;
                tick_timer    = 0;
            end
        end
        per = (mode_reg >= arp_pkg::MODE_FAST) ? fast_ticks : slow_ticks;
        tick_timer++;
        if (tick_timer >= per) begin
            tick_timer = 0;
            if (voiced_count > 0) begin
                if (pat == arp_pkg::PAT_UPDOWN) begin
                    step_pos += step_down ? -1 : 1;
                    if (step_pos >= voiced_count - 1) begin
                        step_pos  = voiced_count - 1;
                        step_down = 1'b1;
                    end else if (step_pos <= 0) begin
                        step_pos  = 0;
                        step_down = 1'b0;
                    end
                end else begin
                    step_pos = (step_pos + 1) % voiced_count;
                end
                sounding_note = voiced_notes[step_pos];
                sounding_gate = 1'b1;
            end
        end
        if (tick_timer > per / 2)
            sounding_gate = 1'b0;
        result = {sounding_gate, sounding_note};
    endtask

    always @(posedge i_clk) begin : monitor
        logic [arp_pkg::M_DATA_W-1:0] want;
        logic [arp_pkg::M_DATA_W-1:0] pred;
        tick_taken = i_s_tvalid && o_s_tready;
        cfg_taken  = i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: %h", o_m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata[arp_pkg::NOTE_W-1:0] !== want[arp_pkg::NOTE_W-1:0]) begin
                        $error("out_note: expected %0d, got %0d",
                               want[arp_pkg::NOTE_W-1:0], o_m_tdata[arp_pkg::NOTE_W-1:0]);
                        errors++;
                    end
                    if (o_m_tdata[arp_pkg::NOTE_W] !== want[arp_pkg::NOTE_W]) begin
                        $error("out_gate: expected %0b, got %0b",
                               want[arp_pkg::NOTE_W], o_m_tdata[arp_pkg::NOTE_W]);
                        errors++;
                    end
                end
            end
            if (tick_taken) begin
                arpeggiate(t_held_tick'(i_s_tdata[$bits(t_held_tick)-1:0]), pred);
                expected_results.push_back(pred);
                ticks_accepted++;
            end
            if (cfg_taken)
                apply_register(i_cfg_addr, i_cfg_data);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || tick_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
                i_s_tdata  <= arp_pkg::S_DATA_W'(tick_queue.pop_front());
                i_s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        case (rx_style)
            RX_STREAM:   i_m_tready <= 1'b1;
            RX_COIN:     i_m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   i_m_tready <= ($urandom_range(0, 3) == 0);
            default:     i_m_tready <= ((rx_left % 8) >= 3);
        endcase
    end

    task automatic queue_tick(input t_held_tick t);
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    task automatic push_chord(input int count, input bit gate,
                              input int chord[arp_pkg::NOTE_FIELDS]);
        t_held_tick t;
        int i;
        t.gate  = gate;
        t.count = arp_pkg::CNT_IN_W'(count);
        for (i = 0; i < arp_pkg::NOTE_FIELDS; i++)
            t.notes[i] = arp_pkg::NOTE_W'(chord[i]);
        queue_tick(t);
    endtask

    task automatic noise_tick();
        logic [63:0] r;
        r = {$urandom, $urandom};
        queue_tick(t_held_tick'(r[$bits(t_held_tick)-1:0]));
    endtask

    // key held for a while, notes added and lifted, then released
    task automatic play_phrase(input int len);
        t_held_tick t;
        logic [63:0] r;
        int cnt, k, sel, pos, i;
        r = {$urandom, $urandom};
        t = r[$bits(t_held_tick)-1:0];
        t.gate = 1'b1;
        cnt = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, arp_pkg::NOTE_FIELDS);
        for (k = 0; k < len; k++) begin
            sel = $urandom_range(0, 11);
            if (sel == 0 && cnt < arp_pkg::NOTE_FIELDS) begin
                t.notes[cnt] = arp_pkg::NOTE_W'($urandom_range(0, 127));
                cnt++;
            end else if (sel == 1 && cnt > 0) begin
                pos = $urandom_range(0, cnt - 1);
                for (i = pos; i < cnt - 1; i++)
                    t.notes[i] = t.notes[i + 1];
                cnt--;
            end else if (sel == 2) begin
                t.notes[$urandom_range(0, arp_pkg::NOTE_FIELDS - 1)] =
                    arp_pkg::NOTE_W'($urandom_range(0, 127));
            end
            if (cnt == arp_pkg::NOTE_FIELDS && $urandom_range(0, 3) == 0)
                t.count = arp_pkg::CNT_IN_W'($urandom_range(arp_pkg::NOTE_FIELDS, 15));
            else
                t.count = arp_pkg::CNT_IN_W'(cnt);
            queue_tick(t);
        end
        t.gate = 1'b0;
        repeat ($urandom_range(1, 3)) begin
            t.count = arp_pkg::CNT_IN_W'($urandom_range(0, 15));
            queue_tick(t);
        end
    endtask

    task automatic write_register(input logic [arp_pkg::CFG_ADDR_W-1:0] addr,
                                  input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= arp_pkg::CFG_DATA_W'(value);
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (ticks_accepted != ticks_queued || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic int pick_period();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(1, 6);
        else if (r < 16)
            return $urandom_range(7, 30);
        else if (r == 16)
            return 0;
        else if (r == 17)
            return 65535;
        else if (r == 18)
            return $urandom_range(31, 65535);
        return 1;
    endfunction

    function automatic int pick_mode();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(int'(arp_pkg::MODE_OFF), int'(arp_pkg::MODE_MAX));
        return $urandom_range(int'(arp_pkg::MODE_MAX) + 1, 15);
    endfunction

    initial begin
        int ph, target;
        reset_arpeggiator();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty list, first notes, oversized count
        push_chord(0, 1'b0, '{0, 0, 0, 0, 0, 0, 0, 0});
        push_chord(0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0});
        push_chord(3, 1'b1, '{127, 0, 64, 0, 0, 0, 0, 0});
        push_chord(15, 1'b1, '{0, 127, 1, 126, 64, 63, 2, 125});
        push_chord(3, 1'b0, '{127, 0, 64, 0, 0, 0, 0, 0});
        wait_idle();

        // up-down stepping every tick, then the list shrinks under the index
        write_register(arp_pkg::REG_ARP_MODE, int'(arp_pkg::PAT_UPDOWN));
        write_register(arp_pkg::REG_SLOW_PERIOD, 0);
        repeat (6) push_chord(4, 1'b1, '{50, 20, 127, 0, 0, 0, 0, 0});
        push_chord(2, 1'b1, '{5, 100, 0, 0, 0, 0, 0, 0});
        push_chord(1, 1'b1, '{77, 0, 0, 0, 0, 0, 0, 0});
        push_chord(0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0});
        push_chord(8, 1'b1, '{9, 120, 33, 0, 127, 64, 1, 80});
        push_chord(8, 1'b0, '{9, 120, 33, 0, 127, 64, 1, 80});
        wait_idle();

        // same mode again, then an out-of-range mode
        write_register(arp_pkg::REG_ARP_MODE, int'(arp_pkg::PAT_UPDOWN));
        write_register(arp_pkg::REG_ARP_MODE, 12);
        write_register(arp_pkg::REG_SLOW_PERIOD, 10);
        repeat (7) push_chord(3, 1'b1, '{10, 90, 45, 0, 0, 0, 0, 0});
        wait_idle();
        write_register(arp_pkg::REG_SLOW_PERIOD, 2);
        repeat (2) push_chord(3, 1'b1, '{10, 90, 45, 0, 0, 0, 0, 0});
        wait_idle();

        write_register(arp_pkg::REG_ARP_MODE, int'(arp_pkg::MODE_MAX));
        write_register(arp_pkg::REG_FAST_PERIOD, 65535);
        write_register(arp_pkg::REG_SLOW_PERIOD, 65535);
        repeat (2) push_chord(5, 1'b1, '{70, 3, 99, 41, 12, 0, 0, 0});

        for (ph = 0; ph < 18; ph++) begin
            wait_idle();
            if ($urandom_range(0, 3) != 0)
                write_register(arp_pkg::REG_SLOW_PERIOD, pick_period());
            if ($urandom_range(0, 3) != 0)
                write_register(arp_pkg::REG_FAST_PERIOD, pick_period());
            if ($urandom_range(0, 3) != 0)
                write_register(arp_pkg::REG_ARP_MODE, pick_mode());
            target = ticks_queued + 50;
            while (ticks_queued < target) begin
                if ($urandom_range(0, 9) < 8)
                    play_phrase($urandom_range(2, 30));
                else
                    noise_tick();
            end
        end
        wait_idle();
        repeat (8) @(negedge i_clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #10000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
